// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srts assertion failed");

`endif

// ----- rtl/srts_pkg.sv -----
// Shared types and constants of the shortest-remaining-time scheduler.
// Used by srts_ctrl, srts_dpath and the top level; depends on nothing.
package srts_pkg;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned CNT_OUT_W = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One process table row as it is kept in the table memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic              started;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic upd;
        logic acc;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic scan_last;
    } t_status;

endpackage

// ----- rtl/srts_ctrl.sv -----
// Controller state machine of the scheduler: sequences load, scan and update.
// Depends on srts_pkg for the command and status structs.
module srts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_op,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srts_pkg::t_cmd      o_cmd,
    input  srts_pkg::t_status   i_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           in_accept;
    srts_pkg::t_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_op == srts_pkg::OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = i_status.empty ? S_UPD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // The last table row read is compared in this cycle.
            S_DRAIN: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.acc = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.acc) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- rtl/srts_dpath.sv -----
// Datapath of the scheduler: process table memory, minimum search, clock,
// running sums and the output register. Depends on srts_pkg.
module srts_dpath #(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srts_pkg::t_cmd                    i_cmd,
    output srts_pkg::t_status                 o_status,
    input  logic [srts_pkg::ID_W-1:0]         i_proc_id,
    input  logic [srts_pkg::TIME_W-1:0]       i_arrival_time,
    input  logic [srts_pkg::TIME_W-1:0]       i_burst_time,
    output logic [srts_pkg::ID_W-1:0]         o_running_id,
    output logic                              o_idle,
    output logic                              o_finished,
    output logic [srts_pkg::TICK_W-1:0]       o_turnaround,
    output logic [srts_pkg::TICK_W-1:0]       o_waiting,
    output logic [srts_pkg::SUM_W-1:0]        o_total_turnaround,
    output logic [srts_pkg::SUM_W-1:0]        o_total_waiting,
    output logic [srts_pkg::SUM_W-1:0]        o_total_response,
    output logic [srts_pkg::CNT_OUT_W-1:0]    o_completed_count,
    output logic                              o_all_done,
    output logic [srts_pkg::TICK_W-1:0]       o_tick_now
);

    srts_pkg::t_entry                  mem [MAX_PROCS];

    logic [CNT_W-1:0]                  r_loaded;
    logic [CNT_W-1:0]                  r_done;
    logic [CNT_W-1:0]                  n_done;
    logic [IDX_W-1:0]                  r_idx;
    logic                              r_rd_vld;
    srts_pkg::t_entry                  r_rd_data;
    logic [IDX_W-1:0]                  r_rd_idx;
    logic                              r_found;
    logic [IDX_W-1:0]                  r_pick;
    srts_pkg::t_entry                  r_best;
    logic [srts_pkg::TICK_W-1:0]       r_clock;
    logic [srts_pkg::TICK_W-1:0]       r_diff;
    logic [srts_pkg::TIME_W-1:0]       r_bm1;
    logic                              r_fin;
    logic                              r_first;
    logic [srts_pkg::SUM_W-1:0]        r_sum_tat;
    logic [srts_pkg::SUM_W-1:0]        r_sum_wt;
    logic [srts_pkg::SUM_W-1:0]        r_sum_resp;
    logic [srts_pkg::SUM_W-1:0]        n_sum_tat;
    logic [srts_pkg::SUM_W-1:0]        n_sum_wt;
    logic [srts_pkg::SUM_W-1:0]        n_sum_resp;

    logic                              full;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    srts_pkg::t_entry                  wr_data;
    srts_pkg::t_entry                  load_entry;
    srts_pkg::t_entry                  upd_entry;
    logic                              eligible;
    logic                              better;
    logic [srts_pkg::TICK_W-1:0]       tat;
    logic [srts_pkg::TICK_W-1:0]       wt;

    assign full               = (r_loaded == CNT_W'(MAX_PROCS));
    assign o_status.empty     = (r_loaded == '0);
    assign o_status.scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_loaded);

    // A zero burst is stored as one tick.
    always_comb begin
        load_entry.id        = i_proc_id;
        load_entry.arrival   = i_arrival_time;
        load_entry.burst     = (i_burst_time == '0) ? srts_pkg::TIME_W'(1) : i_burst_time;
        load_entry.remaining = load_entry.burst;
        load_entry.started   = 1'b0;
        upd_entry            = r_best;
        upd_entry.remaining  = r_best.remaining - srts_pkg::TIME_W'(1);
        upd_entry.started    = 1'b1;
    end

    assign wr_en   = (i_cmd.load && !full) || (i_cmd.upd && r_found);
    assign wr_addr = i_cmd.upd ? r_pick : r_loaded[IDX_W-1:0];
    assign wr_data = i_cmd.upd ? upd_entry : load_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    // Strict compares keep the lower slot on a full tie.
    assign eligible = r_rd_vld && (r_rd_data.remaining != '0) &&
                      (srts_pkg::TICK_W'(r_rd_data.arrival) <= r_clock);
    assign better   = !r_found ||
                      (r_rd_data.remaining < r_best.remaining) ||
                      ((r_rd_data.remaining == r_best.remaining) &&
                       (r_rd_data.arrival < r_best.arrival));

    // r_diff is the old clock minus arrival, so turnaround is r_diff + 1.
    assign tat = r_diff + srts_pkg::TICK_W'(1);
    assign wt  = r_diff - srts_pkg::TICK_W'(r_bm1);

    always_comb begin
        n_sum_tat  = r_sum_tat;
        n_sum_wt   = r_sum_wt;
        n_sum_resp = r_sum_resp;
        n_done     = r_done;
        if (r_fin) begin
            n_sum_tat = r_sum_tat + srts_pkg::SUM_W'(tat);
            n_sum_wt  = r_sum_wt + srts_pkg::SUM_W'(wt);
            n_done    = r_done + CNT_W'(1);
        end
        if (r_first) begin
            n_sum_resp = r_sum_resp + srts_pkg::SUM_W'(r_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_done     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_clock    <= '0;
            r_fin      <= 1'b0;
            r_first    <= 1'b0;
            r_sum_tat  <= '0;
            r_sum_wt   <= '0;
            r_sum_resp <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load && !full) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (eligible && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_clock <= r_clock + srts_pkg::TICK_W'(1);
                r_fin   <= r_found && (r_best.remaining == srts_pkg::TIME_W'(1));
                r_first <= r_found && !r_best.started;
            end
            if (i_cmd.acc) begin
                r_sum_tat  <= n_sum_tat;
                r_sum_wt   <= n_sum_wt;
                r_sum_resp <= n_sum_resp;
                r_done     <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (eligible && better) begin
            r_best <= r_rd_data;
            r_pick <= r_rd_idx;
        end
        if (i_cmd.upd) begin
            r_diff <= r_clock - srts_pkg::TICK_W'(r_best.arrival);
            r_bm1  <= r_best.burst - srts_pkg::TIME_W'(1);
        end
        if (i_cmd.acc) begin
            o_running_id       <= r_found ? r_best.id : '0;
            o_idle             <= !r_found;
            o_finished         <= r_fin;
            o_turnaround       <= r_fin ? tat : '0;
            o_waiting          <= r_fin ? wt : '0;
            o_total_turnaround <= n_sum_tat;
            o_total_waiting    <= n_sum_wt;
            o_total_response   <= n_sum_resp;
            o_completed_count  <= srts_pkg::CNT_OUT_W'(n_done);
            o_all_done         <= (n_done == r_loaded);
            o_tick_now         <= r_clock;
        end
    end

endmodule

// ----- rtl/shortest_remaining_time_scheduler.sv -----
// Shortest-remaining-time-first scheduler, top level.
// The input channel (i_in_valid / o_in_ready) carries load and tick
// transactions. A load (i_op = 0) writes the next table row and
// gives no result; it is dropped when the table holds MAX_PROCS rows.
// A tick (i_op = 1) reads the table one row per cycle through the single read
// port of the table memory to find the least remaining time, then updates
// the chosen row and the running sums. The controller steps from the scan
// through a drain step for the last row read and the update to the result
// write; the result is registered, and the next transaction is taken once
// the controller is idle again. An empty table skips the scan and the drain.
// The result channel (o_out_valid / i_out_ready) is a register: a result
// waits there while the receiver stalls, and loads are still accepted
// meanwhile; the next tick finishes its scan but holds before writing the
// result until the register is free.
// Synchronous active-low reset clears the clock, the sums, the row count and
// the completed count; table rows are valid only once loaded, so no clearing
// pass is needed and the block is ready as soon as reset is released.
// Depends on srts_pkg, srts_ctrl and srts_dpath.
module shortest_remaining_time_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [srts_pkg::ID_W-1:0]         i_proc_id,
    input  logic [srts_pkg::TIME_W-1:0]       i_arrival_time,
    input  logic [srts_pkg::TIME_W-1:0]       i_burst_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [srts_pkg::ID_W-1:0]         o_running_id,
    output logic                              o_idle,
    output logic                              o_finished,
    output logic [srts_pkg::TICK_W-1:0]       o_turnaround,
    output logic [srts_pkg::TICK_W-1:0]       o_waiting,
    output logic [srts_pkg::SUM_W-1:0]        o_total_turnaround,
    output logic [srts_pkg::SUM_W-1:0]        o_total_waiting,
    output logic [srts_pkg::SUM_W-1:0]        o_total_response,
    output logic [srts_pkg::CNT_OUT_W-1:0]    o_completed_count,
    output logic                              o_all_done,
    output logic [srts_pkg::TICK_W-1:0]       o_tick_now
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    srts_pkg::t_cmd    cmd;
    srts_pkg::t_status status;

    srts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    srts_dpath #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_proc_id          (i_proc_id),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .o_running_id       (o_running_id),
        .o_idle             (o_idle),
        .o_finished         (o_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting),
        .o_total_response   (o_total_response),
        .o_completed_count  (o_completed_count),
        .o_all_done         (o_all_done),
        .o_tick_now         (o_tick_now)
    );

endmodule

// ----- rtl/srts_chk.sv -----
// Port-level checker of the scheduler and its bind to the top level.
// Depends on assert_macros.svh and srts_pkg.
`include "assert_macros.svh"

module srts_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_op,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [srts_pkg::ID_W-1:0]         o_running_id,
    input logic                              o_idle,
    input logic                              o_finished,
    input logic [srts_pkg::TICK_W-1:0]       o_turnaround,
    input logic [srts_pkg::TICK_W-1:0]       o_waiting
);

    // A result waiting for the receiver is not withdrawn.
    `SRTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A load transaction never produces a result.
    `SRTS_ASSERT_NXT(a_load_silent, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_op == srts_pkg::OP_LOAD) && !o_out_valid,
        !o_out_valid)

    // After a tick is taken, the block is busy in the next cycle.
    `SRTS_ASSERT_NXT(a_tick_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_op == srts_pkg::OP_TICK), !o_in_ready)

    // An idle tick runs nothing and finishes nothing.
    `SRTS_ASSERT_IMP(a_idle_result, i_clk, i_rst_n, o_out_valid && o_idle,
        (o_running_id == '0) && !o_finished)

    // Times are reported only for a completing process.
    `SRTS_ASSERT_IMP(a_times_zero, i_clk, i_rst_n, o_out_valid && !o_finished,
        (o_turnaround == '0) && (o_waiting == '0))

endmodule

bind shortest_remaining_time_scheduler srts_chk u_srts_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_op         (i_op),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_running_id (o_running_id),
    .o_idle       (o_idle),
    .o_finished   (o_finished),
    .o_turnaround (o_turnaround),
    .o_waiting    (o_waiting)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for shortest_remaining_time_scheduler.
// Depends on srts_pkg and the scheduler RTL; predicts every tick result internally.
module tb;

    localparam int          TABLE_ROWS  = 16;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          PRINT_LIMIT = 100;

    typedef struct packed {
        logic [srts_pkg::ID_W-1:0]      run_id;
        logic                           idle;
        logic                           finished;
        logic [srts_pkg::TICK_W-1:0]    turnaround;
        logic [srts_pkg::TICK_W-1:0]    waiting;
        logic [srts_pkg::SUM_W-1:0]     sum_tat;
        logic [srts_pkg::SUM_W-1:0]     sum_wait;
        logic [srts_pkg::SUM_W-1:0]     sum_resp;
        logic [srts_pkg::CNT_OUT_W-1:0] done_cnt;
        logic                           all_done;
        logic [srts_pkg::TICK_W-1:0]    tick_now;
    } t_tick_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_op;
    logic [srts_pkg::ID_W-1:0]      i_proc_id;
    logic [srts_pkg::TIME_W-1:0]    i_arrival_time;
    logic [srts_pkg::TIME_W-1:0]    i_burst_time;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [srts_pkg::ID_W-1:0]      o_running_id;
    logic                           o_idle;
    logic                           o_finished;
    logic [srts_pkg::TICK_W-1:0]    o_turnaround;
    logic [srts_pkg::TICK_W-1:0]    o_waiting;
    logic [srts_pkg::SUM_W-1:0]     o_total_turnaround;
    logic [srts_pkg::SUM_W-1:0]     o_total_waiting;
    logic [srts_pkg::SUM_W-1:0]     o_total_response;
    logic [srts_pkg::CNT_OUT_W-1:0] o_completed_count;
    logic                           o_all_done;
    logic [srts_pkg::TICK_W-1:0]    o_tick_now;

    t_tick_result                   observed;

    // Shadow copy of the process table and the running statistics.
    logic [srts_pkg::ID_W-1:0]      row_id        [TABLE_ROWS];
    logic [srts_pkg::TIME_W-1:0]    row_arrival   [TABLE_ROWS];
    logic [srts_pkg::TIME_W-1:0]    row_burst     [TABLE_ROWS];
    logic [srts_pkg::TIME_W-1:0]    row_left      [TABLE_ROWS];
    logic                           row_started   [TABLE_ROWS];
    int unsigned                    rows_loaded   = 0;
    int unsigned                    rows_done     = 0;
    logic [srts_pkg::TICK_W-1:0]    sched_clock   = '0;
    logic [srts_pkg::SUM_W-1:0]     acc_tat       = '0;
    logic [srts_pkg::SUM_W-1:0]     acc_wait      = '0;
    logic [srts_pkg::SUM_W-1:0]     acc_resp      = '0;

    t_tick_result                   expected_ticks[$];
    int unsigned                    fail_count         = 0;
    int unsigned                    sender_gap_pct     = 0;
    int unsigned                    receiver_stall_pct = 0;

    shortest_remaining_time_scheduler #(
        .MAX_PROCS(TABLE_ROWS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_proc_id          (i_proc_id),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_running_id       (o_running_id),
        .o_idle             (o_idle),
        .o_finished         (o_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting),
        .o_total_response   (o_total_response),
        .o_completed_count  (o_completed_count),
        .o_all_done         (o_all_done),
        .o_tick_now         (o_tick_now)
    );

    assign observed = {o_running_id, o_idle, o_finished, o_turnaround, o_waiting,
                       o_total_turnaround, o_total_waiting, o_total_response,
                       o_completed_count, o_all_done, o_tick_now};

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Runs one scheduling tick on the shadow table and returns what the block should report.
    function automatic t_tick_result schedule_one_tick();
        t_tick_result                r;
        int unsigned                 pick;
        bit                          found;
        logic [srts_pkg::TICK_W-1:0] elapsed;
        r     = '0;
        r.idle = 1'b1;
        pick  = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < rows_loaded; i++) begin
            if (row_left[i] != '0 && {16'h0, row_arrival[i]} <= sched_clock) begin
                if (!found || row_left[i] < row_left[pick] ||
                    (row_left[i] == row_left[pick] && row_arrival[i] < row_arrival[pick])) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            r.idle   = 1'b0;
            r.run_id = row_id[pick];
            if (!row_started[pick]) begin
                row_started[pick] = 1'b1;
                elapsed  = sched_clock - {16'h0, row_arrival[pick]};
                acc_resp = acc_resp + {16'h0, elapsed};
            end
            row_left[pick] = row_left[pick] - 16'd1;
        end
        sched_clock = sched_clock + 32'd1;
        if (found && row_left[pick] == '0) begin
            r.finished   = 1'b1;
            r.turnaround = sched_clock - {16'h0, row_arrival[pick]};
            r.waiting    = r.turnaround - {16'h0, row_burst[pick]};
            acc_tat      = acc_tat + {16'h0, r.turnaround};
            acc_wait     = acc_wait + {16'h0, r.waiting};
            rows_done++;
        end
        r.sum_tat  = acc_tat;
        r.sum_wait = acc_wait;
        r.sum_resp = acc_resp;
        r.done_cnt = srts_pkg::CNT_OUT_W'(rows_done);
        r.all_done = (rows_done == rows_loaded);
        r.tick_now = sched_clock;
        return r;
    endfunction

    task automatic apply_transaction(input logic op, input logic [srts_pkg::ID_W-1:0] id,
                                     input logic [srts_pkg::TIME_W-1:0] arrival,
                                     input logic [srts_pkg::TIME_W-1:0] burst);
        if (op == srts_pkg::OP_LOAD) begin
            // A full table drops the load without touching anything.
            if (rows_loaded < TABLE_ROWS) begin
                row_id[rows_loaded]      = id;
                row_arrival[rows_loaded] = arrival;
                row_burst[rows_loaded]   = (burst == '0) ? 16'd1 : burst;
                row_left[rows_loaded]    = (burst == '0) ? 16'd1 : burst;
                row_started[rows_loaded] = 1'b0;
                rows_loaded++;
            end
        end else begin
            expected_ticks.push_back(schedule_one_tick());
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [srts_pkg::SUM_W-1:0] got,
                                   input logic [srts_pkg::SUM_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    endtask

    task automatic check_tick_result(input t_tick_result got, input t_tick_result want);
        if (got.run_id !== want.run_id)
            report_mismatch("running_id", srts_pkg::SUM_W'(got.run_id),
                            srts_pkg::SUM_W'(want.run_id));
        if (got.idle !== want.idle)
            report_mismatch("idle", srts_pkg::SUM_W'(got.idle), srts_pkg::SUM_W'(want.idle));
        if (got.finished !== want.finished)
            report_mismatch("finished", srts_pkg::SUM_W'(got.finished),
                            srts_pkg::SUM_W'(want.finished));
        if (got.turnaround !== want.turnaround)
            report_mismatch("turnaround", srts_pkg::SUM_W'(got.turnaround),
                            srts_pkg::SUM_W'(want.turnaround));
        if (got.waiting !== want.waiting)
            report_mismatch("waiting", srts_pkg::SUM_W'(got.waiting),
                            srts_pkg::SUM_W'(want.waiting));
        if (got.sum_tat !== want.sum_tat)
            report_mismatch("total_turnaround", got.sum_tat, want.sum_tat);
        if (got.sum_wait !== want.sum_wait)
            report_mismatch("total_waiting", got.sum_wait, want.sum_wait);
        if (got.sum_resp !== want.sum_resp)
            report_mismatch("total_response", got.sum_resp, want.sum_resp);
        if (got.done_cnt !== want.done_cnt)
            report_mismatch("completed_count", srts_pkg::SUM_W'(got.done_cnt),
                            srts_pkg::SUM_W'(want.done_cnt));
        if (got.all_done !== want.all_done)
            report_mismatch("all_done", srts_pkg::SUM_W'(got.all_done),
                            srts_pkg::SUM_W'(want.all_done));
        if (got.tick_now !== want.tick_now)
            report_mismatch("tick_now", srts_pkg::SUM_W'(got.tick_now),
                            srts_pkg::SUM_W'(want.tick_now));
    endtask

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ticks.size() == 0)
                report_mismatch("result with nothing expected",
                                srts_pkg::SUM_W'(o_running_id), '0);
            else
                check_tick_result(observed, expected_ticks.pop_front());
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Sends one transaction, with a random gap first, and predicts it once accepted.
    task automatic send_item(input logic op, input logic [srts_pkg::ID_W-1:0] id,
                             input logic [srts_pkg::TIME_W-1:0] arrival,
                             input logic [srts_pkg::TIME_W-1:0] burst);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_gap_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_proc_id      <= id;
        i_arrival_time <= arrival;
        i_burst_time   <= burst;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        apply_transaction(op, id, arrival, burst);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_ticks.size() != 0);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count)
            send_item(srts_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_empty_table();
        // Nothing loaded: idle ticks that still report all processes done.
        send_ticks(2);
    endtask

    task automatic test_zero_burst_late_load();
        // Arrival already in the past and a burst of zero, which runs as one tick.
        send_item(srts_pkg::OP_LOAD, 8'h00, 16'h0000, 16'h0000);
        send_ticks(1);
    endtask

    task automatic test_idle_until_arrival();
        send_item(srts_pkg::OP_LOAD, 8'hFF, 16'd5, 16'd2);
        send_ticks(4);
    endtask

    task automatic test_preemption_and_ties();
        // Equal remaining and arrival goes to the lower slot; equal remaining
        // with an earlier arrival beats a lower slot; a short late job runs before longer ones.
        send_item(srts_pkg::OP_LOAD, 8'hA5, 16'd7, 16'd3);
        send_item(srts_pkg::OP_LOAD, 8'h5A, 16'd7, 16'd3);
        send_item(srts_pkg::OP_LOAD, 8'h3C, 16'd8, 16'd1);
        send_item(srts_pkg::OP_LOAD, 8'hC3, 16'd6, 16'd2);
        send_ticks(9);
    endtask

    task automatic random_traffic(input int unsigned n_items, input int unsigned gap_pct,
                                  input int unsigned stall_pct, input bit drain_midway);
        logic [srts_pkg::TIME_W-1:0] arrival;
        logic [srts_pkg::TIME_W-1:0] burst;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (drain_midway && k == n_items / 2)
                hold_until_drained();
            if ($urandom_range(99) < 8) begin
                if (rows_loaded < TABLE_ROWS) begin
                    // Well-formed load: arrival near the current tick, mostly short work.
                    if ($urandom_range(3) == 0)
                        arrival = 16'($urandom_range(sched_clock));
                    else
                        arrival = 16'(sched_clock + $urandom_range(150));
                    if ($urandom_range(2) == 0)
                        burst = 16'($urandom_range(400, 1));
                    else
                        burst = 16'($urandom_range(12));
                end else begin
                    arrival = 16'($urandom);
                    burst   = 16'($urandom);
                end
                send_item(srts_pkg::OP_LOAD, 8'($urandom), arrival, burst);
            end else begin
                send_ticks(1);
            end
        end
    endtask

    task automatic test_random_no_idle();
        random_traffic(450, 0, 0, 1'b0);
    endtask

    task automatic test_random_sender_gaps();
        random_traffic(450, 50, 0, 1'b1);
    endtask

    task automatic test_random_receiver_stalls();
        random_traffic(450, 0, 50, 1'b0);
    endtask

    task automatic test_random_both_idle();
        random_traffic(450, 33, 33, 1'b0);
    endtask

    task automatic test_table_full_drop();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        while (rows_loaded < TABLE_ROWS)
            send_item(srts_pkg::OP_LOAD, 8'($urandom), 16'(sched_clock), 16'd1);
        // Loads beyond capacity carry the field extremes and must be ignored.
        send_item(srts_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(srts_pkg::OP_LOAD, 8'h00, 16'h0000, 16'h0000);
        send_item(srts_pkg::OP_LOAD, 8'h55, 16'hAAAA, 16'h5555);
        send_ticks(3);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= srts_pkg::OP_LOAD;
        i_proc_id      <= '0;
        i_arrival_time <= '0;
        i_burst_time   <= '0;
        i_out_ready    <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_zero_burst_late_load();
        test_idle_until_arrival();
        test_preemption_and_ties();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_table_full_drop();

        hold_until_drained();
        repeat (30) @(posedge i_clk);
        if (expected_ticks.size() != 0)
            report_mismatch("results never delivered",
                            srts_pkg::SUM_W'(expected_ticks.size()), '0);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
